FILE: rtl/lfe_pkg.sv
// ----------------------------------------------------------------------------
// lfe_pkg
// Shared types and constants of the LMS FFE/DFE equalizer: field widths,
// fixed-point limits, register map and configuration defaults.
// ----------------------------------------------------------------------------
package lfe_pkg;

	// field widths
	localparam int SMP_W  = 16;   // Q1.14 sample and reference
	localparam int TAP_W  = 20;   // Q3.16 taps
	localparam int Y_W    = 18;   // Q3.14 equalized value and error
	localparam int STEP_W = 16;   // Q0.16 step sizes
	localparam int LAG_W  = 13;
	localparam int PHS_W  = 3;
	localparam int CNT_W  = 16;
	localparam int HIST_W = 2;    // decision history: -1, 0, +1
	localparam int ACC_W  = 26;   // dot product accumulator, holds 48 terms

	// shared multiplier operand and product widths
	localparam int MA_W = 34;
	localparam int MB_W = 18;
	localparam int MP_W = MA_W + MB_W;

	// truncating shifts
	localparam int DOT_SH  = 16;
	localparam int DFE_SH  = 2;
	localparam int FUPD_SH = 28;
	localparam int DUPD_SH = 14;

	// fixed-point limits
	localparam int TAP_MAX = 524287;
	localparam int TAP_MIN = -524288;
	localparam int Y_MAX   = 131071;
	localparam int Y_MIN   = -131072;
	localparam logic signed [TAP_W-1:0] TAP_ONE = 20'sd65536;

	// default structure
	localparam int FFE_TAPS_DEF    = 8;
	localparam int MAIN_CURSOR_DEF = 2;
	localparam int DFE_TAPS_DEF    = 2;
	localparam int OVERSAMPLE_DEF  = 8;

	// configuration port
	localparam int PADDR_W = 5;
	localparam int PDATA_W = 32;

	typedef enum logic [2:0] {
		REG_SAMPLE_PHASE = 3'd0,
		REG_DECISION_LAG = 3'd1,
		REG_DFE_ENABLE   = 3'd2,
		REG_FFE_STEP     = 3'd3,
		REG_DFE_STEP     = 3'd4
	} reg_idx_t;

	localparam logic [PHS_W-1:0]  SAMPLE_PHASE_RST = 3'd0;
	localparam logic [LAG_W-1:0]  DECISION_LAG_RST = 13'd0;
	localparam logic              DFE_ENABLE_RST   = 1'b1;
	localparam logic [STEP_W-1:0] FFE_STEP_RST     = 16'd655;
	localparam logic [STEP_W-1:0] DFE_STEP_RST     = 16'd328;

	typedef struct packed {
		logic [PHS_W-1:0]  sample_phase;
		logic [LAG_W-1:0]  decision_lag;   // two's complement
		logic              dfe_enable;
		logic [STEP_W-1:0] ffe_step;
		logic [STEP_W-1:0] dfe_step;
	} cfg_t;

endpackage

FILE: rtl/lfe_cfg.sv
// ----------------------------------------------------------------------------
// lfe_cfg
// APB-style configuration registers of the equalizer, word addressed at
// 4*index. Writes to unmapped addresses are dropped, reads return zero.
// ----------------------------------------------------------------------------
module lfe_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [lfe_pkg::PADDR_W-1:0] paddr,
	input  logic [lfe_pkg::PDATA_W-1:0] pwdata,
	output logic [lfe_pkg::PDATA_W-1:0] prdata,
	output logic                        pready,
	output lfe_pkg::cfg_t               cfg
);
	import lfe_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sample_phase <= SAMPLE_PHASE_RST;
			cfg_q.decision_lag <= DECISION_LAG_RST;
			cfg_q.dfe_enable   <= DFE_ENABLE_RST;
			cfg_q.ffe_step     <= FFE_STEP_RST;
			cfg_q.dfe_step     <= DFE_STEP_RST;
		end else if (wr_en) begin
			unique case (idx)
				REG_SAMPLE_PHASE: cfg_q.sample_phase <= pwdata[PHS_W-1:0];
				REG_DECISION_LAG: cfg_q.decision_lag <= pwdata[LAG_W-1:0];
				REG_DFE_ENABLE:   cfg_q.dfe_enable   <= pwdata[0];
				REG_FFE_STEP:     cfg_q.ffe_step     <= pwdata[STEP_W-1:0];
				REG_DFE_STEP:     cfg_q.dfe_step     <= pwdata[STEP_W-1:0];
				default: ;
			endcase
		end
	end

	// register read, lag sign extended
	always_comb begin
		unique case (idx)
			REG_SAMPLE_PHASE: prdata = PDATA_W'(cfg_q.sample_phase);
			REG_DECISION_LAG: prdata = PDATA_W'(signed'(cfg_q.decision_lag));
			REG_DFE_ENABLE:   prdata = PDATA_W'(cfg_q.dfe_enable);
			REG_FFE_STEP:     prdata = PDATA_W'(cfg_q.ffe_step);
			REG_DFE_STEP:     prdata = PDATA_W'(cfg_q.dfe_step);
			default:          prdata = '0;
		endcase
	end

endmodule

FILE: rtl/lms_ffe_dfe_equalizer.sv
// ----------------------------------------------------------------------------
// lms_ffe_dfe_equalizer
// Adaptive LMS feed-forward / decision-feedback equalizer on an oversampled
// ADC stream, with all tap arithmetic on one shared multiplier.
// ----------------------------------------------------------------------------
// Every accepted sample is shifted into the FFE window. At the configured
// phase, once the sample count exceeds the lag, the sample starts a decision
// sequence and in_ready stays low until it ends. The sequence runs on one
// shared 34x18 multiplier: a multiply and an accumulate step per FFE tap for
// the dot product, an accumulate step per DFE tap (if enabled), a slice step,
// and with a valid reference a step product then a multiply and an add step
// per FFE tap for the FFE update, and a step product and an update step per
// DFE tap for the DFE update (if enabled), then a step that hands the result
// to the output register. Samples that take no decision are accepted back to
// back. The output register frees the input side while a result waits; a
// second result waits in the last sequence step until the first is taken.
module lms_ffe_dfe_equalizer #(
	parameter int FFE_TAPS    = lfe_pkg::FFE_TAPS_DEF,
	parameter int MAIN_CURSOR = lfe_pkg::MAIN_CURSOR_DEF,
	parameter int DFE_TAPS    = lfe_pkg::DFE_TAPS_DEF,
	parameter int OVERSAMPLE  = lfe_pkg::OVERSAMPLE_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [lfe_pkg::PADDR_W-1:0]       paddr,
	input  logic [lfe_pkg::PDATA_W-1:0]       pwdata,
	output logic [lfe_pkg::PDATA_W-1:0]       prdata,
	output logic                              pready,
	// sample request
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [lfe_pkg::SMP_W-1:0]  adc_sample,
	input  logic signed [lfe_pkg::SMP_W-1:0]  reference,
	input  logic                              reference_valid,
	// result request
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [lfe_pkg::Y_W-1:0]    equalized,
	output logic signed [lfe_pkg::Y_W-1:0]    slice_error,
	output logic                              decision
);
	import lfe_pkg::*;

	localparam int FIDX_W = (FFE_TAPS > 1) ? $clog2(FFE_TAPS) : 1;
	localparam int DIDX_W = (DFE_TAPS > 1) ? $clog2(DFE_TAPS) : 1;
	localparam int IDX_W  = (FIDX_W > DIDX_W) ? FIDX_W : DIDX_W;
	localparam int PH_W   = (OVERSAMPLE > 1) ? $clog2(OVERSAMPLE) : 1;
	localparam int CMP_W  = (PH_W > PHS_W) ? PH_W : PHS_W;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DOT_MUL,
		S_DOT_ACC,
		S_DFE_ACC,
		S_SLICE,
		S_FSTEP,
		S_FUPD_MUL,
		S_FUPD_ADD,
		S_DSTEP,
		S_DUPD,
		S_DONE
	} state_t;

	cfg_t cfg;

	lfe_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// state
	state_t                    state_q;
	logic signed [SMP_W-1:0]   win_q [FFE_TAPS];
	logic signed [TAP_W-1:0]   tap_q [FFE_TAPS];
	logic signed [TAP_W-1:0]   fb_q  [DFE_TAPS];
	logic signed [HIST_W-1:0]  hist_q [DFE_TAPS];
	logic [CNT_W-1:0]          cnt_q;
	logic [PH_W-1:0]           phase_q;
	logic [IDX_W-1:0]          idx_q;
	logic signed [SMP_W-1:0]   ref_q;
	logic                      rv_q;
	logic signed [ACC_W-1:0]   acc_q;
	logic signed [MP_W-1:0]    prod_q;
	logic signed [MA_W-1:0]    se_q;
	logic signed [Y_W-1:0]     y_q;
	logic signed [Y_W-1:0]     e_q;
	logic                      d_q;
	logic                      out_valid_q;
	logic signed [Y_W-1:0]     equalized_q;
	logic signed [Y_W-1:0]     slice_error_q;
	logic                      decision_q;

	// combinational helpers
	logic [FIDX_W-1:0]         fi;
	logic [DIDX_W-1:0]         di;
	logic                      f_last;
	logic                      d_last;
	logic                      fire;
	logic [PH_W:0]             ph_inc;
	logic signed [MA_W-1:0]    mul_a;
	logic signed [MB_W-1:0]    mul_b;
	logic signed [MP_W-1:0]    mul_p;
	logic signed [Y_W-1:0]     y_n;
	logic signed [ACC_W-1:0]   diff_n;
	logic signed [Y_W-1:0]     e_n;
	logic signed [TAP_W+4:0]   fsum;
	logic                      out_load;

	function automatic logic signed [Y_W-1:0] sat_y(input logic signed [ACC_W-1:0] v);
		if (v > ACC_W'(Y_MAX))
			return Y_W'(Y_MAX);
		else if (v < ACC_W'(Y_MIN))
			return Y_W'(Y_MIN);
		else
			return Y_W'(v);
	endfunction

	function automatic logic signed [TAP_W-1:0] sat_tap(input logic signed [TAP_W+4:0] v);
		if (v > (TAP_W+5)'(TAP_MAX))
			return TAP_W'(TAP_MAX);
		else if (v < (TAP_W+5)'(TAP_MIN))
			return TAP_W'(TAP_MIN);
		else
			return TAP_W'(v);
	endfunction

	// feedback tap times past decision, truncated
	function automatic logic signed [TAP_W:0] fb_term(input logic signed [TAP_W-1:0] t,
			input logic signed [HIST_W-1:0] h);
		logic signed [TAP_W:0] tx;
		tx = (TAP_W+1)'(t);
		if (h == 2'sb01)
			return tx >>> DFE_SH;
		else if (h == 2'sb11)
			return (-tx) >>> DFE_SH;
		else
			return '0;
	endfunction

	// step times error times past decision, truncated
	function automatic logic signed [MA_W-DUPD_SH:0] dupd_term(input logic signed [MA_W-1:0] s,
			input logic signed [HIST_W-1:0] h);
		logic signed [MA_W:0] sx;
		logic signed [MA_W:0] sh;
		sx = (MA_W+1)'(s);
		if (h == 2'sb01)
			sh = sx >>> DUPD_SH;
		else if (h == 2'sb11)
			sh = (-sx) >>> DUPD_SH;
		else
			sh = '0;
		return (MA_W-DUPD_SH+1)'(sh);
	endfunction

	assign fi     = idx_q[FIDX_W-1:0];
	assign di     = idx_q[DIDX_W-1:0];
	assign f_last = (idx_q == IDX_W'(FFE_TAPS - 1));
	assign d_last = (idx_q == IDX_W'(DFE_TAPS - 1));

	// decision condition and phase wrap for the arriving sample
	assign fire   = (CMP_W'(phase_q) == CMP_W'(cfg.sample_phase)) &&
	                (signed'({1'b0, cnt_q}) > (CNT_W+1)'(signed'(cfg.decision_lag)));
	assign ph_inc = (PH_W+1)'(phase_q) + (PH_W+1)'(1);

	// shared multiplier operand select
	always_comb begin
		unique case (state_q)
			S_DOT_MUL: begin
				mul_a = MA_W'(tap_q[fi]);
				mul_b = MB_W'(win_q[fi]);
			end
			S_FSTEP: begin
				mul_a = MA_W'(e_q);
				mul_b = MB_W'(signed'({1'b0, cfg.ffe_step}));
			end
			S_FUPD_MUL: begin
				mul_a = se_q;
				mul_b = MB_W'(win_q[fi]);
			end
			S_DSTEP: begin
				mul_a = MA_W'(e_q);
				mul_b = MB_W'(signed'({1'b0, cfg.dfe_step}));
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// slicer and error
	assign y_n    = sat_y(acc_q);
	assign diff_n = ACC_W'(ref_q) - ACC_W'(y_n);
	assign e_n    = rv_q ? sat_y(diff_n) : '0;

	// FFE tap update sum
	assign fsum = (TAP_W+5)'(tap_q[fi]) + (TAP_W+5)'(signed'(prod_q[MP_W-1:FUPD_SH]));

	assign out_load = (state_q == S_DONE) && (!out_valid_q || out_ready);

	// sequencer, tap state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			for (int k = 0; k < FFE_TAPS; k++) begin
				win_q[k] <= '0;
				tap_q[k] <= (k == MAIN_CURSOR) ? TAP_ONE : '0;
			end
			for (int k = 0; k < DFE_TAPS; k++) begin
				fb_q[k]   <= '0;
				hist_q[k] <= '0;
			end
			cnt_q         <= '0;
			phase_q       <= '0;
			idx_q         <= '0;
			ref_q         <= '0;
			rv_q          <= 1'b0;
			acc_q         <= '0;
			prod_q        <= '0;
			se_q          <= '0;
			y_q           <= '0;
			e_q           <= '0;
			d_q           <= 1'b0;
			out_valid_q   <= 1'b0;
			equalized_q   <= '0;
			slice_error_q <= '0;
			decision_q    <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && !out_load)
				out_valid_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						for (int k = FFE_TAPS - 1; k > 0; k--)
							win_q[k] <= win_q[k-1];
						win_q[0] <= adc_sample;
						if (cnt_q != '1)
							cnt_q <= cnt_q + CNT_W'(1);
						phase_q <= (ph_inc >= (PH_W+1)'(OVERSAMPLE)) ? '0 : ph_inc[PH_W-1:0];
						ref_q   <= reference;
						rv_q    <= reference_valid;
						idx_q   <= '0;
						acc_q   <= '0;
						if (fire)
							state_q <= S_DOT_MUL;
					end
				end
				S_DOT_MUL: begin
					prod_q  <= mul_p;
					state_q <= S_DOT_ACC;
				end
				S_DOT_ACC: begin
					acc_q <= acc_q + ACC_W'(signed'(prod_q[MP_W-1:DOT_SH]));
					if (f_last) begin
						idx_q   <= '0;
						state_q <= cfg.dfe_enable ? S_DFE_ACC : S_SLICE;
					end else begin
						idx_q   <= idx_q + IDX_W'(1);
						state_q <= S_DOT_MUL;
					end
				end
				S_DFE_ACC: begin
					acc_q <= acc_q - ACC_W'(fb_term(fb_q[di], hist_q[di]));
					if (d_last)
						state_q <= S_SLICE;
					else
						idx_q <= idx_q + IDX_W'(1);
				end
				S_SLICE: begin
					y_q     <= y_n;
					e_q     <= e_n;
					d_q     <= !y_n[Y_W-1];
					state_q <= rv_q ? S_FSTEP : S_DONE;
				end
				S_FSTEP: begin
					se_q    <= MA_W'(mul_p);
					idx_q   <= '0;
					state_q <= S_FUPD_MUL;
				end
				S_FUPD_MUL: begin
					prod_q  <= mul_p;
					state_q <= S_FUPD_ADD;
				end
				S_FUPD_ADD: begin
					tap_q[fi] <= sat_tap(fsum);
					if (f_last) begin
						state_q <= cfg.dfe_enable ? S_DSTEP : S_DONE;
					end else begin
						idx_q   <= idx_q + IDX_W'(1);
						state_q <= S_FUPD_MUL;
					end
				end
				S_DSTEP: begin
					se_q    <= MA_W'(mul_p);
					idx_q   <= '0;
					state_q <= S_DUPD;
				end
				S_DUPD: begin
					fb_q[di] <= sat_tap((TAP_W+5)'(fb_q[di]) -
					                    (TAP_W+5)'(dupd_term(se_q, hist_q[di])));
					if (d_last)
						state_q <= S_DONE;
					else
						idx_q <= idx_q + IDX_W'(1);
				end
				S_DONE: begin
					if (out_load) begin
						out_valid_q   <= 1'b1;
						equalized_q   <= y_q;
						slice_error_q <= e_q;
						decision_q    <= d_q;
						for (int k = DFE_TAPS - 1; k > 0; k--)
							hist_q[k] <= hist_q[k-1];
						hist_q[0] <= d_q ? 2'sb01 : 2'sb11;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready    = (state_q == S_IDLE);
	assign out_valid   = out_valid_q;
	assign equalized   = equalized_q;
	assign slice_error = slice_error_q;
	assign decision    = decision_q;

	// checks
	a_dec_sign: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (decision == !equalized[Y_W-1]))
		else $error("decision disagrees with sign of equalized value");

	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		(PH_W+1)'(phase_q) < (PH_W+1)'(OVERSAMPLE))
		else $error("phase counter out of range");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		(idx_q < IDX_W'(FFE_TAPS - 1)) || (idx_q < IDX_W'(DFE_TAPS - 1)) || f_last || d_last)
		else $error("tap index out of range");

	a_cnt_mono: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> (cnt_q == $past(cnt_q) + CNT_W'(1)) || (cnt_q == '1))
		else $error("sample count did not advance on an accepted sample");

endmodule

FILE: tb/sv/lms_ffe_dfe_equalizer_test.sv
// ----------------------------------------------------------------------------
// lms_ffe_dfe_equalizer_test
// Self-checking bench for the LMS FFE/DFE equalizer. Oversampled sample
// requests go in through a queue-fed driver. A bit-exact predictor
// computes the equalized value, slice error and decision that each accepted
// sample should produce. A monitor compares every result request against
// those expectations. The bench sweeps the register settings and the sender
// and receiver idle patterns. It also sets the lag just ahead of the
// running sample count so that decisions start partway through a phase.
// ----------------------------------------------------------------------------
module lms_ffe_dfe_equalizer_test;
	import lfe_pkg::*;

	localparam int FFE_N          = FFE_TAPS_DEF;
	localparam int DFE_N          = DFE_TAPS_DEF;
	localparam int CURSOR         = MAIN_CURSOR_DEF;
	localparam int OSR            = OVERSAMPLE_DEF;
	localparam int SMP_FS         = 16384;        // +/- 1.0 in Q1.14
	localparam int CNT_MAX        = 65535;
	localparam int SPARE_REG_IDX  = 7;            // decodes to no register
	localparam int SETTLE_CYCLES  = 64;           // longer than one full decision
	localparam int RX_HOLD_CYCLES = 400;
	localparam int CYCLE_LIMIT    = 2000000;
	localparam int MAX_REPORTS    = 100;
	localparam int PHASE_SAMPLES  = 350;

	typedef struct {
		logic signed [SMP_W-1:0] adc;
		logic signed [SMP_W-1:0] trn;
		logic                    trn_vld;
	} smp_req_t;

	typedef struct {
		logic signed [Y_W-1:0] equalized;
		logic signed [Y_W-1:0] slice_err;
		logic                  decision;
	} slice_t;

	// DUT signals
	logic                      clk             = 1'b0;
	logic                      arst_n          = 1'b0;
	logic                      psel            = 1'b0;
	logic                      penable         = 1'b0;
	logic                      pwrite          = 1'b0;
	logic [PADDR_W-1:0]        paddr           = '0;
	logic [PDATA_W-1:0]        pwdata          = '0;
	logic [PDATA_W-1:0]        prdata;
	logic                      pready;
	logic                      in_valid        = 1'b0;
	logic                      in_ready;
	logic signed [SMP_W-1:0]   adc_sample      = '0;
	logic signed [SMP_W-1:0]   reference       = '0;
	logic                      reference_valid = 1'b0;
	logic                      out_valid;
	logic                      out_ready       = 1'b0;
	logic signed [Y_W-1:0]     equalized;
	logic signed [Y_W-1:0]     slice_error;
	logic                      decision;

	// stimulus and scoreboard
	smp_req_t    stim_q[$];
	slice_t      expected_slices[$];
	smp_req_t    cur_req;
	int unsigned n_pushed      = 0;
	int unsigned n_accepted    = 0;
	int unsigned n_results     = 0;
	int unsigned n_decisions   = 0;
	int unsigned n_trained     = 0;
	int unsigned n_clipped     = 0;
	int unsigned n_settings    = 0;
	int unsigned err_cnt       = 0;
	int unsigned cycle_cnt     = 0;
	int unsigned snd_idle_pct  = 0;
	int unsigned rcv_idle_pct  = 0;
	int unsigned hold_trigger  = 0;
	int unsigned hold_seen     = 0;
	int unsigned rx_hold_left  = 0;

	// line-like stimulus generator state
	int sym_cur  = SMP_FS;
	int sym_prev = SMP_FS;
	int sym_pos  = 0;

	// equalizer mirror: configuration
	logic [PHS_W-1:0]        cfg_phase;
	logic signed [LAG_W-1:0] cfg_lag;
	logic                    cfg_dfe_en;
	logic [STEP_W-1:0]       cfg_ffe_step;
	logic [STEP_W-1:0]       cfg_dfe_step;

	// equalizer mirror: state
	logic signed [SMP_W-1:0] win     [FFE_N];
	logic signed [TAP_W-1:0] ffe_tap [FFE_N];
	logic signed [TAP_W-1:0] dfe_tap [DFE_N];
	int                      hist    [DFE_N];   // -1, 0 (none yet), +1
	int                      smp_cnt;
	int                      phs_cnt;

	lms_ffe_dfe_equalizer i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.prdata          (prdata),
		.pready          (pready),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.adc_sample      (adc_sample),
		.reference       (reference),
		.reference_valid (reference_valid),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.equalized       (equalized),
		.slice_error     (slice_error),
		.decision        (decision)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic longint clamp(longint v, longint lo, longint hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	// mirror of the block's reset state
	task automatic reset_mirror();
		int k;
		cfg_phase    = SAMPLE_PHASE_RST;
		cfg_lag      = DECISION_LAG_RST;
		cfg_dfe_en   = DFE_ENABLE_RST;
		cfg_ffe_step = FFE_STEP_RST;
		cfg_dfe_step = DFE_STEP_RST;
		for (k = 0; k < FFE_N; k++) begin
			win[k]     = '0;
			ffe_tap[k] = (k == CURSOR) ? TAP_ONE : '0;
		end
		for (k = 0; k < DFE_N; k++) begin
			dfe_tap[k] = '0;
			hist[k]    = 0;
		end
		smp_cnt = 0;
		phs_cnt = 0;
	endtask

	function automatic void apply_reg(int idx, logic [PDATA_W-1:0] val);
		case (idx)
			REG_SAMPLE_PHASE: cfg_phase    = val[PHS_W-1:0];
			REG_DECISION_LAG: cfg_lag      = val[LAG_W-1:0];
			REG_DFE_ENABLE:   cfg_dfe_en   = val[0];
			REG_FFE_STEP:     cfg_ffe_step = val[STEP_W-1:0];
			REG_DFE_STEP:     cfg_dfe_step = val[STEP_W-1:0];
			default: ;        // unmapped address, write dropped
		endcase
	endfunction

	// Shift one sample in; on a decision, slice, adapt and queue the result.
	task automatic equalize_sample(input smp_req_t rq);
		int     k;
		bit     fire;
		longint acc;
		longint y;
		longint err;
		int     d;
		slice_t res;
		for (k = FFE_N - 1; k > 0; k--)
			win[k] = win[k-1];
		win[0] = rq.adc;
		fire = (phs_cnt == int'(cfg_phase)) && (smp_cnt > int'(cfg_lag));
		if (smp_cnt < CNT_MAX)
			smp_cnt++;
		phs_cnt = (phs_cnt + 1 >= OSR) ? 0 : phs_cnt + 1;
		if (fire) begin
			// dot product, each term floored on its own
			acc = 0;
			for (k = 0; k < FFE_N; k++)
				acc += (longint'(ffe_tap[k]) * longint'(win[k])) >>> DOT_SH;
			if (cfg_dfe_en)
				for (k = 0; k < DFE_N; k++)
					acc -= (longint'(dfe_tap[k]) * hist[k]) >>> DFE_SH;
			y = clamp(acc, Y_MIN, Y_MAX);
			d = (y < 0) ? -1 : 1;
			err = 0;
			// LMS update only with a training symbol
			if (rq.trn_vld) begin
				err = clamp(longint'(rq.trn) - y, Y_MIN, Y_MAX);
				for (k = 0; k < FFE_N; k++)
					ffe_tap[k] = TAP_W'(clamp(longint'(ffe_tap[k]) +
						((longint'(cfg_ffe_step) * err * longint'(win[k])) >>> FUPD_SH),
						TAP_MIN, TAP_MAX));
				if (cfg_dfe_en)
					for (k = 0; k < DFE_N; k++)
						dfe_tap[k] = TAP_W'(clamp(longint'(dfe_tap[k]) -
							((longint'(cfg_dfe_step) * err * hist[k]) >>> DUPD_SH),
							TAP_MIN, TAP_MAX));
				n_trained++;
			end
			// history shifts even with the DFE bypassed
			for (k = DFE_N - 1; k > 0; k--)
				hist[k] = hist[k-1];
			hist[0] = d;
			if (y == Y_MIN || y == Y_MAX)
				n_clipped++;
			n_decisions++;
			res.equalized = y[Y_W-1:0];
			res.slice_err = err[Y_W-1:0];
			res.decision  = (d > 0);
			expected_slices.push_back(res);
		end
	endtask

	// Mostly +/-1 symbols through a short ISI channel with noise, some junk.
	function automatic smp_req_t next_line_sample(int unsigned train_pct);
		smp_req_t rq;
		int       v;
		if ($urandom_range(99) < 15) begin
			rq.adc     = SMP_W'(int'($urandom_range(2 * SMP_FS)) - SMP_FS);
			rq.trn     = SMP_W'(int'($urandom_range(2 * SMP_FS)) - SMP_FS);
			rq.trn_vld = 1'($urandom_range(1));
		end else begin
			if (sym_pos == 0) begin
				sym_prev = sym_cur;
				sym_cur  = $urandom_range(1) ? SMP_FS : -SMP_FS;
			end
			sym_pos    = (sym_pos + 1) % OSR;
			v          = (3 * sym_cur + sym_prev) / 4 + int'($urandom_range(2048)) - 1024;
			rq.adc     = SMP_W'(clamp(v, -SMP_FS, SMP_FS));
			rq.trn     = SMP_W'(sym_cur);
			rq.trn_vld = ($urandom_range(99) < train_pct);
		end
		return rq;
	endfunction

	task automatic flag_mismatch(input string what);
		err_cnt++;
		// keep the log bounded when the block is badly off
		if (err_cnt <= MAX_REPORTS)
			$display("MISMATCH at %0t: %s", $time, what);
	endtask

	// APB write: setup cycle, then access until pready
	task automatic reg_write(input int idx, input logic [PDATA_W-1:0] val);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= PADDR_W'(idx * 4);
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		apply_reg(idx, val);
	endtask

	// every sample taken and every result back, then let the block settle
	task automatic wait_idle();
		do @(negedge clk); while (n_accepted != n_pushed || expected_slices.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic run_phase(input int phase, input int lag, input int dfe_on,
			input int fstep, input int dstep, input int unsigned snd_pct,
			input int unsigned rcv_pct, input bit hold, input int n,
			input int unsigned train_pct);
		int k;
		wait_idle();
		reg_write(REG_SAMPLE_PHASE, phase);
		reg_write(REG_DECISION_LAG, lag & ((1 << LAG_W) - 1));
		reg_write(REG_DFE_ENABLE, dfe_on);
		reg_write(REG_FFE_STEP, fstep);
		reg_write(REG_DFE_STEP, dstep);
		reg_write(SPARE_REG_IDX, $urandom);
		n_settings++;
		@(negedge clk);
		snd_idle_pct = snd_pct;
		rcv_idle_pct = rcv_pct;
		for (k = 0; k < n; k++) begin
			stim_q.push_back(next_line_sample(train_pct));
			n_pushed++;
		end
		// receiver stalls while the sender keeps pushing
		if (hold) begin
			@(posedge clk);
			hold_trigger <= hold_trigger + 1;
		end
	endtask

	// sample request driver
	always @(posedge clk) begin : sample_driver
		if (arst_n) begin
			if (in_valid && in_ready) begin
				equalize_sample(cur_req);
				n_accepted++;
			end
			if (!in_valid || in_ready) begin
				if (stim_q.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
					cur_req = stim_q.pop_front();
					in_valid        <= 1'b1;
					adc_sample      <= cur_req.adc;
					reference       <= cur_req.trn;
					reference_valid <= cur_req.trn_vld;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result request monitor
	always @(posedge clk) begin : result_monitor
		slice_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				n_results++;
				if (expected_slices.size() == 0) begin
					flag_mismatch($sformatf("result %0d with nothing expected", n_results));
				end else begin
					want = expected_slices.pop_front();
					if (equalized !== want.equalized)
						flag_mismatch($sformatf("result %0d equalized %0d, expected %0d",
							n_results, equalized, want.equalized));
					if (slice_error !== want.slice_err)
						flag_mismatch($sformatf("result %0d slice_error %0d, expected %0d",
							n_results, slice_error, want.slice_err));
					if (decision !== want.decision)
						flag_mismatch($sformatf("result %0d decision %b, expected %b",
							n_results, decision, want.decision));
				end
			end
			out_ready <= (rx_hold_left == 0) && ($urandom_range(99) >= rcv_idle_pct);
		end
	end

	// long receiver hold-off, counted here
	always @(posedge clk) begin : rx_hold_timer
		if (hold_seen != hold_trigger) begin
			hold_seen    <= hold_trigger;
			rx_hold_left <= RX_HOLD_CYCLES;
		end else if (rx_hold_left != 0) begin
			rx_hold_left <= rx_hold_left - 1;
		end
	end

	always @(posedge clk) begin : watchdog
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin : stimulus
		smp_req_t rq;
		int       k;
		reset_mirror();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: full-scale and zero samples at reset settings; the first
		// decision sees a zero sample on the main cursor and has no training
		for (k = 0; k < 25; k++) begin
			case (k % 3)
				0: rq.adc = '0;
				1: rq.adc = SMP_W'(SMP_FS);
				default: rq.adc = SMP_W'(-SMP_FS);
			endcase
			rq.trn     = SMP_W'(((k / 8) % 2) ? -SMP_FS : SMP_FS);
			rq.trn_vld = (k != 8);
			stim_q.push_back(rq);
			n_pushed++;
		end

		// sender idles a little, receiver a lot; negative lag fires at once
		run_phase(3, -64, 1, 655, 328, 20, 85, 1'b0, PHASE_SAMPLES, 80);
		// the other way round, DFE bypassed, full FFE step
		run_phase(7, 0, 0, 65535, 0, 85, 20, 1'b0, PHASE_SAMPLES, 80);
		// no idling, long receiver hold-off, frozen FFE, full DFE step
		run_phase(0, 100, 1, 0, 65535, 0, 0, 1'b1, PHASE_SAMPLES, 80);
		// random settings
		run_phase($urandom_range(7), int'($urandom_range(1000)) - 64, 1,
			$urandom_range(65535), $urandom_range(65535), 0, 0, 1'b0, PHASE_SAMPLES, 80);
		// lag just ahead of the sample count, decisions start partway in
		run_phase(1, 1600, 1, 300, 200, 0, 0, 1'b0, PHASE_SAMPLES, 6);
		// both steps at full scale
		run_phase(6, -1, 1, 65535, 65535, 0, 0, 1'b0, 250, 90);
		wait_idle();

		$display("Ran %0d samples over %0d register settings: %0d decisions checked",
			n_accepted, n_settings, n_results);
		$display("%0d trained, %0d clipped, sample counter at %0d", n_trained,
			n_clipped, smp_cnt);
		if (err_cnt == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
